### rtl/core/idt_pkg.sv
// Shared types and codes for the dihedral image transform frame store.
package idt_pkg;

    typedef enum logic [2:0] {
        MODE_IDENTITY       = 3'd0,
        MODE_LEFT_RIGHT     = 3'd1,
        MODE_TOP_DOWN       = 3'd2,
        MODE_TRANSPOSE      = 3'd3,
        MODE_ROT90          = 3'd4,
        MODE_ROT180         = 3'd5,
        MODE_ROT270         = 3'd6,
        MODE_ANTI_TRANSPOSE = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DELIVER
    } state_t;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int SIZE_BITS  = 9;
    localparam int COUNT_BITS = 2 * SIZE_BITS;
    localparam int WORD_BITS  = 32;

    typedef struct packed {
        logic                 last;
        logic                 empty;
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
    } result_meta_t;

    function automatic logic transposes(mode_t m);
        logic t;
        case (m) inside
            MODE_TRANSPOSE, MODE_ROT90, MODE_ROT270, MODE_ANTI_TRANSPOSE: t = 1'b1;
            default: t = 1'b0;
        endcase
        return t;
    endfunction

endpackage

### rtl/core/idt_cmd_if.sv
// Command channel carrying load and fetch transactions.
interface idt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [idt_pkg::WORD_BITS-1:0] pixel_in;

    modport source (output valid, output command, output pixel_in, input ready);
    modport sink (input valid, input command, input pixel_in, output ready);
endinterface

### rtl/core/idt_res_if.sv
// Result channel carrying one transaction per fetch.
interface idt_res_if;
    logic                          valid;
    logic                          ready;
    logic [idt_pkg::WORD_BITS-1:0] pixel_out;
    logic [idt_pkg::SIZE_BITS-1:0] out_width;
    logic [idt_pkg::SIZE_BITS-1:0] out_height;
    logic                          last;
    logic                          empty_res;

    modport source (
        output valid, output pixel_out, output out_width, output out_height,
        output last, output empty_res, input ready
    );
    modport sink (
        input valid, input pixel_out, input out_width, input out_height,
        input last, input empty_res, output ready
    );
endinterface

### rtl/core/image_dihedral_transform.sv
// Frame store that reads out an image under one of the eight symmetries of the square.
//
// Load transactions write pixels in raster order into a single-port-write,
// single-port-read frame memory of MAX_WIDTH*MAX_HEIGHT words; loads past
// width*height are dropped. A fetch forms the source address (coordinate mirror
// plus one row-times-width multiply) into an address register, then does the
// registered memory read, then loads the output register once it is free. The
// command channel accepts one transaction at a time, so a new fetch is not taken
// until the last one has loaded the output register; a fetch before the frame is
// complete still takes the output path but skips the memory. The frame memory
// needs no clearing after reset. A write to the mode, width or height register
// restarts the frame (load count and read position return to 0).
module image_dihedral_transform #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [1:0]                    cfg_index,
    input  logic [idt_pkg::SIZE_BITS-1:0] cfg_data,
    idt_cmd_if.sink                       cmd,
    idt_res_if.source                     res
);

    localparam int Depth     = MAX_WIDTH * MAX_HEIGHT;
    localparam int AddrBits  = $clog2(Depth);
    localparam int SizeBits  = idt_pkg::SIZE_BITS;
    localparam int CountBits = idt_pkg::COUNT_BITS;
    localparam logic [SizeBits-1:0] WidthReset  = SizeBits'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
    localparam logic [SizeBits-1:0] HeightReset =
        SizeBits'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

    function automatic logic [SizeBits-1:0] clamp_size(logic [SizeBits-1:0] v, int max_size);
        logic [SizeBits-1:0] r;
        if (v == '0)
            r = SizeBits'(1);
        else if (32'(v) > max_size)
            r = SizeBits'(max_size);
        else
            r = v;
        return r;
    endfunction

    logic [PIXEL_BITS-1:0] frame_mem [Depth];

    idt_pkg::mode_t        mode_reg, mode_next;
    logic [SizeBits-1:0]   width_reg, width_next;
    logic [SizeBits-1:0]   height_reg, height_next;
    logic [CountBits-1:0]  load_count_reg, load_count_next;
    logic [SizeBits-1:0]   out_row_reg, out_row_next;
    logic [SizeBits-1:0]   out_col_reg, out_col_next;
    logic                  frame_ready_reg, frame_ready_next;
    idt_pkg::state_t       state_reg, state_next;
    logic                  res_valid_reg, res_valid_next;

    logic [AddrBits-1:0]   addr_reg;
    logic [PIXEL_BITS-1:0] rd_data_reg;
    idt_pkg::result_meta_t meta_reg, meta_next;
    idt_pkg::result_meta_t res_meta_reg;
    logic [idt_pkg::WORD_BITS-1:0] res_pixel_reg;

    logic                  accept;
    logic                  is_fetch;
    logic                  load_we;
    logic                  out_free;
    logic                  deliver;
    logic                  xpose;
    logic [SizeBits-1:0]   ow, oh;
    logic [SizeBits-1:0]   src_x, src_y;
    logic [CountBits-1:0]  frame_size;
    logic [CountBits-1:0]  src_addr;
    logic                  at_last;

    assign cmd.ready  = (state_reg == idt_pkg::ST_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign is_fetch   = (cmd.command == idt_pkg::CMD_FETCH);
    assign load_we    = accept && !is_fetch && !frame_ready_reg;
    assign out_free   = !res_valid_reg || res.ready;
    assign deliver    = (state_reg == idt_pkg::ST_DELIVER) && out_free;

    assign xpose      = idt_pkg::transposes(mode_reg);
    assign ow         = xpose ? height_reg : width_reg;
    assign oh         = xpose ? width_reg : height_reg;
    assign frame_size = CountBits'(width_reg) * CountBits'(height_reg);
    assign at_last    = (out_row_reg == oh - SizeBits'(1)) && (out_col_reg == ow - SizeBits'(1));

    always_comb
    begin
        unique case (mode_reg)
            idt_pkg::MODE_IDENTITY:
            begin
                src_x = out_col_reg;
                src_y = out_row_reg;
            end
            idt_pkg::MODE_LEFT_RIGHT:
            begin
                src_x = width_reg - SizeBits'(1) - out_col_reg;
                src_y = out_row_reg;
            end
            idt_pkg::MODE_TOP_DOWN:
            begin
                src_x = out_col_reg;
                src_y = height_reg - SizeBits'(1) - out_row_reg;
            end
            idt_pkg::MODE_TRANSPOSE:
            begin
                src_x = out_row_reg;
                src_y = out_col_reg;
            end
            idt_pkg::MODE_ROT90:
            begin
                src_x = width_reg - SizeBits'(1) - out_row_reg;
                src_y = out_col_reg;
            end
            idt_pkg::MODE_ROT180:
            begin
                src_x = width_reg - SizeBits'(1) - out_col_reg;
                src_y = height_reg - SizeBits'(1) - out_row_reg;
            end
            idt_pkg::MODE_ROT270:
            begin
                src_x = out_row_reg;
                src_y = height_reg - SizeBits'(1) - out_col_reg;
            end
            default:
            begin
                src_x = width_reg - SizeBits'(1) - out_row_reg;
                src_y = height_reg - SizeBits'(1) - out_col_reg;
            end
        endcase
    end

    assign src_addr = CountBits'(src_y) * CountBits'(width_reg) + CountBits'(src_x);

    always_comb
    begin
        mode_next        = mode_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        load_count_next  = load_count_reg;
        out_row_next     = out_row_reg;
        out_col_next     = out_col_reg;
        frame_ready_next = frame_ready_reg;
        state_next       = state_reg;
        res_valid_next   = res_valid_reg;
        meta_next        = meta_reg;

        if (deliver)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            idt_pkg::ST_IDLE:
            begin
                if (accept && is_fetch)
                begin
                    meta_next.width  = ow;
                    meta_next.height = oh;
                    meta_next.empty  = !frame_ready_reg;
                    meta_next.last   = frame_ready_reg && at_last;
                    state_next       = frame_ready_reg ? idt_pkg::ST_READ : idt_pkg::ST_DELIVER;
                end
            end
            idt_pkg::ST_READ:
            begin
                state_next = idt_pkg::ST_DELIVER;
            end
            idt_pkg::ST_DELIVER:
            begin
                if (out_free)
                    state_next = idt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = idt_pkg::ST_IDLE;
            end
        endcase

        if (load_we)
        begin
            load_count_next = load_count_reg + CountBits'(1);
            if (load_count_next >= frame_size)
                frame_ready_next = 1'b1;
        end

        if (accept && is_fetch && frame_ready_reg)
        begin
            if (out_col_reg + SizeBits'(1) >= ow)
            begin
                out_col_next = '0;
                out_row_next = (out_row_reg + SizeBits'(1) >= oh) ? '0 : out_row_reg + SizeBits'(1);
            end
            else
            begin
                out_col_next = out_col_reg + SizeBits'(1);
            end
        end

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                idt_pkg::CFG_MODE:   mode_next   = idt_pkg::mode_t'(cfg_data[2:0]);
                idt_pkg::CFG_WIDTH:  width_next  = clamp_size(cfg_data, MAX_WIDTH);
                idt_pkg::CFG_HEIGHT: height_next = clamp_size(cfg_data, MAX_HEIGHT);
                default: ;
            endcase
            if (cfg_index == idt_pkg::CFG_MODE || cfg_index == idt_pkg::CFG_WIDTH
                || cfg_index == idt_pkg::CFG_HEIGHT)
            begin
                load_count_next  = '0;
                out_row_next     = '0;
                out_col_next     = '0;
                frame_ready_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= idt_pkg::MODE_IDENTITY;
            width_reg       <= WidthReset;
            height_reg      <= HeightReset;
            load_count_reg  <= '0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            frame_ready_reg <= 1'b0;
            state_reg       <= idt_pkg::ST_IDLE;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            load_count_reg  <= load_count_next;
            out_row_reg     <= out_row_next;
            out_col_reg     <= out_col_next;
            frame_ready_reg <= frame_ready_next;
            state_reg       <= state_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
        if (accept && is_fetch)
            addr_reg <= AddrBits'(src_addr);
        if (deliver)
        begin
            res_meta_reg  <= meta_reg;
            res_pixel_reg <= meta_reg.empty ? '0 : idt_pkg::WORD_BITS'(rd_data_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
            frame_mem[AddrBits'(load_count_reg)] <= PIXEL_BITS'(cmd.pixel_in);
        if (state_reg == idt_pkg::ST_READ)
            rd_data_reg <= frame_mem[addr_reg];
    end

    assign res.valid      = res_valid_reg;
    assign res.pixel_out  = res_pixel_reg;
    assign res.out_width  = res_meta_reg.width;
    assign res.out_height = res_meta_reg.height;
    assign res.last       = res_meta_reg.last;
    assign res.empty_res  = res_meta_reg.empty;

`ifndef NO_ASSERTIONS
    a_empty_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.empty_res |-> res.pixel_out == '0 && !res.last)
        else $error("early fetch result carries pixel or last");

    a_ready_fetch_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_fetch && frame_ready_reg |=> state_reg == idt_pkg::ST_READ)
        else $error("ready fetch skipped the memory read");

    a_load_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= frame_size)
        else $error("load count ran past the frame size");

    a_ready_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready_reg |-> load_count_reg == frame_size)
        else $error("frame ready without a full frame loaded");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready_reg |-> out_col_reg < ow && out_row_reg < oh)
        else $error("read position outside the output frame");
`endif

endmodule

### tb/tb_image_dihedral_transform.sv
// Self-checking testbench for the dihedral image transform frame store.
module tb_image_dihedral_transform;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_W        = 256;
    localparam int MAX_H        = 256;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1500;

    localparam logic       CMD_LOAD   = idt_pkg::CMD_LOAD;
    localparam logic       CMD_FETCH  = idt_pkg::CMD_FETCH;
    localparam logic [1:0] CFG_MODE   = idt_pkg::CFG_MODE;
    localparam logic [1:0] CFG_WIDTH  = idt_pkg::CFG_WIDTH;
    localparam logic [1:0] CFG_HEIGHT = idt_pkg::CFG_HEIGHT;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] pixel;
        logic [8:0]  out_w;
        logic [8:0]  out_h;
        logic        last;
        logic        empty;
    } pixel_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_CMD,
        ROW_CMD_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [1:0]    reg_index;
        logic [8:0]    reg_value;
        logic          command;
        logic [31:0]   pixel;
        pixel_result_t want;
    } stim_row_t;

    localparam pixel_result_t NO_RES = '0;

    localparam stim_row_t DIRECTED [31] = '{
        '{ROW_CMD_TYPED, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, '{32'd0, 9'd256, 9'd256, 1'b0, 1'b1}},
        '{ROW_CFG, CFG_MODE, {6'h3F, idt_pkg::MODE_TRANSPOSE}, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CFG, CFG_WIDTH, 9'd0, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CFG, CFG_HEIGHT, 9'd511, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CMD_TYPED, CFG_MODE, 9'd0, CMD_FETCH, 32'hFFFF_FFFF,
          '{32'd0, 9'd256, 9'd1, 1'b0, 1'b1}},
        '{ROW_CFG, CFG_UNUSED, 9'd5, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CMD_TYPED, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, '{32'd0, 9'd256, 9'd1, 1'b0, 1'b1}},
        '{ROW_CFG, CFG_MODE, {6'd0, idt_pkg::MODE_ROT90}, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CFG, CFG_WIDTH, 9'd3, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CFG, CFG_HEIGHT, 9'd2, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'h0000_0000, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'hFFFF_FFFF, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'h8000_0000, NO_RES},
        '{ROW_CMD_TYPED, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, '{32'd0, 9'd2, 9'd3, 1'b0, 1'b1}},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'h0000_0001, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'hA5A5_A5A5, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'h5A5A_5A5A, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'h1234_5678, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_FETCH, 32'd0, NO_RES},
        '{ROW_CFG, CFG_WIDTH, 9'd1, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CFG, CFG_HEIGHT, 9'd1, CMD_LOAD, 32'd0, NO_RES},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'hFFFF_FFFF, NO_RES},
        '{ROW_CMD_TYPED, CFG_MODE, 9'd0, CMD_FETCH, 32'd0,
          '{32'hFFFF_FFFF, 9'd1, 9'd1, 1'b1, 1'b0}},
        '{ROW_CMD, CFG_MODE, 9'd0, CMD_LOAD, 32'h0000_0000, NO_RES},
        '{ROW_CMD_TYPED, CFG_MODE, 9'd0, CMD_FETCH, 32'd0,
          '{32'hFFFF_FFFF, 9'd1, 9'd1, 1'b1, 1'b0}}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write_en;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    idt_cmd_if cmd_bus ();
    idt_res_if res_bus ();

    image_dihedral_transform #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .PIXEL_BITS (32)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd_bus),
        .res          (res_bus)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Shadow copy of the frame store and its read position
    bit [31:0]       shadow_store [MAX_W * MAX_H];
    int unsigned     shadow_loaded;
    int unsigned     shadow_row;
    int unsigned     shadow_col;
    bit              shadow_ready;
    idt_pkg::mode_t  shadow_mode;
    int unsigned     shadow_w;
    int unsigned     shadow_h;

    pixel_result_t expected_pixels [$];
    int            error_count = 0;
    int            useful_items = 0;
    int            burst_left = 0;
    bit            steady_sender = 1'b0;

    function automatic int unsigned clamp_dim(logic [8:0] value, int unsigned limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return 32'(value);
    endfunction

    function automatic void shadow_config(logic [1:0] idx, logic [8:0] value);
        case (idx)
            CFG_MODE:   shadow_mode = idt_pkg::mode_t'(value[2:0]);
            CFG_WIDTH:  shadow_w = clamp_dim(value, MAX_W);
            CFG_HEIGHT: shadow_h = clamp_dim(value, MAX_H);
            default:    return;
        endcase
        shadow_loaded = 0;
        shadow_row    = 0;
        shadow_col    = 0;
        shadow_ready  = 1'b0;
    endfunction

    function automatic void track_command(logic command, logic [31:0] pixel, logic typed,
                                          pixel_result_t want);
        pixel_result_t outcome;
        int unsigned   ow;
        int unsigned   oh;
        int unsigned   sx;
        int unsigned   sy;
        int unsigned   i;
        int unsigned   j;
        logic          swap;

        swap = shadow_mode inside {idt_pkg::MODE_TRANSPOSE, idt_pkg::MODE_ROT90,
                                   idt_pkg::MODE_ROT270, idt_pkg::MODE_ANTI_TRANSPOSE};
        ow = swap ? shadow_h : shadow_w;
        oh = swap ? shadow_w : shadow_h;
        if (command == CMD_LOAD)
        begin
            if (!shadow_ready)
            begin
                shadow_store[shadow_loaded] = pixel;
                shadow_loaded++;
                useful_items++;
                if (shadow_loaded >= shadow_w * shadow_h)
                    shadow_ready = 1'b1;
            end
            return;
        end
        useful_items++;
        outcome       = '0;
        outcome.out_w = ow[8:0];
        outcome.out_h = oh[8:0];
        outcome.empty = !shadow_ready;
        if (shadow_ready)
        begin
            i = shadow_col;
            j = shadow_row;
            sx = 0;
            sy = 0;
            case (shadow_mode)
                idt_pkg::MODE_IDENTITY:
                begin
                    sx = i;
                    sy = j;
                end
                idt_pkg::MODE_LEFT_RIGHT:
                begin
                    sx = shadow_w - 1 - i;
                    sy = j;
                end
                idt_pkg::MODE_TOP_DOWN:
                begin
                    sx = i;
                    sy = shadow_h - 1 - j;
                end
                idt_pkg::MODE_TRANSPOSE:
                begin
                    sx = j;
                    sy = i;
                end
                idt_pkg::MODE_ROT90:
                begin
                    sx = shadow_w - 1 - j;
                    sy = i;
                end
                idt_pkg::MODE_ROT180:
                begin
                    sx = shadow_w - 1 - i;
                    sy = shadow_h - 1 - j;
                end
                idt_pkg::MODE_ROT270:
                begin
                    sx = j;
                    sy = shadow_h - 1 - i;
                end
                idt_pkg::MODE_ANTI_TRANSPOSE:
                begin
                    sx = shadow_w - 1 - j;
                    sy = shadow_h - 1 - i;
                end
            endcase
            outcome.pixel = shadow_store[sy * shadow_w + sx];
            outcome.last  = (j == oh - 1) && (i == ow - 1);
            if (i + 1 >= ow)
            begin
                shadow_col = 0;
                shadow_row = (j + 1 >= oh) ? 0 : j + 1;
            end
            else
            begin
                shadow_col = i + 1;
            end
        end
        expected_pixels.push_back(typed ? want : outcome);
    endfunction

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(logic command, logic [31:0] pixel, logic typed,
                                pixel_result_t want);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                9:             gap = $urandom_range(8, 30);
                default:       gap = $urandom_range(1, 4);
            endcase
            if (steady_sender)
                gap = 0;
            if (gap > 0)
            begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_bus.valid    <= 1'b1;
        cmd_bus.command  <= command;
        cmd_bus.pixel_in <= pixel;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        track_command(command, pixel, typed, want);
    endtask

    task automatic write_register(logic [1:0] idx, logic [8:0] value);
        cmd_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        shadow_config(idx, value);
    endtask

    task automatic run_phase(int phase_no);
        logic [8:0]  w_val;
        logic [8:0]  h_val;
        logic [8:0]  mode_val;
        int unsigned total;
        int unsigned reads;
        int unsigned partial;
        int          base;

        mode_val = 9'($urandom_range(0, 511));
        w_val    = 9'($urandom_range(1, 8));
        h_val    = 9'($urandom_range(1, 8));
        if (phase_no == 0)
        begin
            w_val = 9'($urandom_range(256, 511));
            h_val = 9'($urandom_range(0, 1));
        end
        else if (phase_no == 1)
        begin
            w_val = 9'($urandom_range(0, 1));
            h_val = 9'($urandom_range(256, 511));
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            if ($urandom_range(0, 1))
                w_val = $urandom_range(0, 1) ? 9'($urandom_range(256, 511)) : 9'd0;
            else
                h_val = $urandom_range(0, 1) ? 9'($urandom_range(256, 511)) : 9'd0;
        end

        base = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
        begin
            case ((base + k) % 3)
                0:       write_register(CFG_MODE, mode_val);
                1:       write_register(CFG_WIDTH, w_val);
                default: write_register(CFG_HEIGHT, h_val);
            endcase
        end
        if ($urandom_range(0, 19) == 0)
            write_register(CFG_UNUSED, 9'($urandom_range(0, 511)));

        total         = shadow_w * shadow_h;
        steady_sender = ($urandom_range(0, 4) == 0);
        burst_left    = 0;

        // Broken sequence: partial frame with early fetches, then abandon it
        if (phase_no > 1 && $urandom_range(0, 9) == 0)
        begin
            partial = $urandom_range(0, total - 1);
            for (int k = 0; k < partial; k++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_command(CMD_FETCH, $urandom, 1'b0, NO_RES);
                send_command(CMD_LOAD, random_pixel(), 1'b0, NO_RES);
            end
            repeat ($urandom_range(1, 3))
                send_command(CMD_FETCH, $urandom, 1'b0, NO_RES);
            return;
        end

        for (int k = 0; k < total; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_command(CMD_FETCH, $urandom, 1'b0, NO_RES);
            send_command(CMD_LOAD, random_pixel(), 1'b0, NO_RES);
        end
        repeat ($urandom_range(0, 3))
            send_command(CMD_LOAD, random_pixel(), 1'b0, NO_RES);

        if (total > 64)
            reads = total + 1;
        else
            reads = total * $urandom_range(1, 2) + $urandom_range(0, total);
        for (int k = 0; k < reads; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_command(CMD_LOAD, random_pixel(), 1'b0, NO_RES);
            send_command(CMD_FETCH, $urandom, 1'b0, NO_RES);
        end
    endtask

    // Result side: stall pattern and checking
    initial
    begin
        logic [15:0]   ready_mask;
        int unsigned   pattern_age;
        pixel_result_t want;

        res_bus.ready = 1'b0;
        ready_mask    = 16'hFFFF;
        pattern_age   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result transaction with no fetch pending");
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (res_bus.pixel_out !== want.pixel)
                    begin
                        $error("pixel_out: expected %h, got %h", want.pixel, res_bus.pixel_out);
                        error_count++;
                    end
                    if (res_bus.out_width !== want.out_w)
                    begin
                        $error("out_width: expected %0d, got %0d", want.out_w,
                               res_bus.out_width);
                        error_count++;
                    end
                    if (res_bus.out_height !== want.out_h)
                    begin
                        $error("out_height: expected %0d, got %0d", want.out_h,
                               res_bus.out_height);
                        error_count++;
                    end
                    if (res_bus.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, res_bus.last);
                        error_count++;
                    end
                    if (res_bus.empty_res !== want.empty)
                    begin
                        $error("empty_res: expected %b, got %b", want.empty, res_bus.empty_res);
                        error_count++;
                    end
                end
            end
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: ready_mask = 16'hFFFF;
                    3:       ready_mask = 16'($urandom & $urandom & $urandom);
                    default: ready_mask = 16'($urandom);
                endcase
                if (ready_mask == 0)
                    ready_mask = 16'h0001;
                pattern_age = $urandom_range(40, 300);
            end
            else
            begin
                pattern_age--;
            end
            ready_mask = {ready_mask[14:0], ready_mask[15]};
            res_bus.ready <= ready_mask[0];
        end
    end

    initial
    begin
        #(CLK_PERIOD * 1_000_000);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int phase_no;
        int target;

        rst_n            = 1'b0;
        cfg_write_en     = 1'b0;
        cfg_index        = CFG_MODE;
        cfg_data         = '0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.command  = CMD_LOAD;
        cmd_bus.pixel_in = '0;
        shadow_mode      = idt_pkg::MODE_IDENTITY;
        shadow_w         = clamp_dim(9'd256, MAX_W);
        shadow_h         = clamp_dim(9'd256, MAX_H);
        shadow_loaded    = 0;
        shadow_row       = 0;
        shadow_col       = 0;
        shadow_ready     = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k])
        begin
            case (DIRECTED[k].kind)
                ROW_CFG:
                    write_register(DIRECTED[k].reg_index, DIRECTED[k].reg_value);
                ROW_CMD:
                    send_command(DIRECTED[k].command, DIRECTED[k].pixel, 1'b0, NO_RES);
                default:
                    send_command(DIRECTED[k].command, DIRECTED[k].pixel, 1'b1,
                                 DIRECTED[k].want);
            endcase
        end

        target   = useful_items + RANDOM_ITEMS;
        phase_no = 0;
        while (useful_items < target)
        begin
            run_phase(phase_no);
            phase_no++;
        end

        cmd_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/idt_pkg.sv
rtl/core/idt_cmd_if.sv
rtl/core/idt_res_if.sv
rtl/core/image_dihedral_transform.sv
tb/tb_image_dihedral_transform.sv
